FILE: src/pmt_pkg.sv
// shared types and constants of the pgn movetext tokenizer
package pmt_pkg;

  typedef enum logic [2:0] {
    MODE_SEEK,
    MODE_TOKEN,
    MODE_BRACE,
    MODE_LINE,
    MODE_VAR,
    MODE_VAR_BRACE,
    MODE_VAR_LINE,
    MODE_DASH
  } pmt_mode_e;

  typedef enum logic [1:0] {
    CAUSE_RUN      = 2'd0,
    CAUSE_TEXT_END = 2'd1,
    CAUSE_STRAY    = 2'd2,
    CAUSE_UNCLOSED = 2'd3
  } pmt_cause_e;

  typedef struct packed {
    logic [7:0] move_char;
    logic       char_valid;
    logic       token_first;
    logic       token_final;
    logic       section_done;
    pmt_cause_e stop_cause;
  } pmt_result_t;

  // results of one byte: count is 0, 1 or 2, res0 filled first
  typedef struct packed {
    logic [1:0]  count;
    pmt_result_t res0;
    pmt_result_t res1;
  } pmt_step_t;

  localparam int unsigned ResDepth = 4;
  localparam int unsigned ResPtrW  = 2;
  localparam int unsigned ResCntW  = 3;

endpackage

FILE: src/pmt_lexer.sv
// scan state and per-byte token logic of the movetext tokenizer
module pmt_lexer #(
  parameter int unsigned MAX_NEST = 15
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  input  logic              last_i,
  output pmt_pkg::pmt_step_t step_o
);

  localparam int unsigned DepthW = $clog2(MAX_NEST + 1);
  localparam logic [DepthW-1:0] MaxNestD = DepthW'(MAX_NEST);

  localparam logic [7:0] ChBraceOpen  = 8'h7B;
  localparam logic [7:0] ChBraceClose = 8'h7D;
  localparam logic [7:0] ChSemi       = 8'h3B;
  localparam logic [7:0] ChParOpen    = 8'h28;
  localparam logic [7:0] ChParClose   = 8'h29;
  localparam logic [7:0] ChDollar     = 8'h24;
  localparam logic [7:0] ChDash       = 8'h2D;
  localparam logic [7:0] ChDot        = 8'h2E;
  localparam logic [7:0] ChSpace      = 8'h20;
  localparam logic [7:0] ChTab        = 8'h09;
  localparam logic [7:0] ChNewline    = 8'h0A;
  localparam logic [7:0] ChNul        = 8'h00;

  function automatic logic is_gap(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || c == ChDot || c == ChDollar ||
           c == ChNewline || c == ChSpace;
  endfunction

  function automatic logic is_move_start(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h68) || c == 8'h4B || c == 8'h51 ||
           c == 8'h52 || c == 8'h42 || c == 8'h4E || c == 8'h4F;
  endfunction

  function automatic logic is_token_end(input logic [7:0] c);
    return c == ChSpace || c == ChTab || c == ChNewline || c == ChNul;
  endfunction

  function automatic pmt_pkg::pmt_result_t mk_char(input logic [7:0] c, input logic first,
                                                   input logic final_c);
    pmt_pkg::pmt_result_t r;
    r              = '0;
    r.move_char    = c;
    r.char_valid   = 1'b1;
    r.token_first  = first;
    r.token_final  = final_c;
    r.stop_cause   = pmt_pkg::CAUSE_RUN;
    return r;
  endfunction

  function automatic pmt_pkg::pmt_result_t mk_done(input pmt_pkg::pmt_cause_e cause);
    pmt_pkg::pmt_result_t r;
    r              = '0;
    r.section_done = 1'b1;
    r.stop_cause   = cause;
    return r;
  endfunction

  pmt_pkg::pmt_mode_e mode_q, mode_d;
  logic [DepthW-1:0]  depth_q, depth_d;
  logic [7:0]         held_q, held_d;
  logic               two_q, two_d;     // token holds at least two characters
  logic               start_q, start_d;
  logic               stopped_q, stopped_d;
  logic               pend_q, pend_d;   // held character opens its token

  pmt_pkg::pmt_step_t  st;
  pmt_pkg::pmt_result_t fin;
  logic                stray;
  logic [DepthW-1:0]   depth_dec;

  always_comb begin
    mode_d    = mode_q;
    depth_d   = depth_q;
    held_d    = held_q;
    two_d     = two_q;
    start_d   = start_q;
    stopped_d = stopped_q;
    pend_d    = pend_q;
    st        = '0;
    fin       = '0;
    stray     = 1'b0;
    depth_dec = (depth_q != '0) ? depth_q - 1'b1 : depth_q;

    if (stopped_q) begin
      if (last_i) begin
        stopped_d = 1'b0;
        start_d   = 1'b1;
      end
    end else if (start_q) begin
      start_d = 1'b0;
      if (last_i) begin
        st.count = 2'd1;
        st.res0  = mk_done(pmt_pkg::CAUSE_TEXT_END);
        start_d  = 1'b1;
      end
    end else begin
      case (mode_q)
        pmt_pkg::MODE_SEEK: begin
          if (is_gap(byte_i)) begin
          end else if (byte_i == ChDash) begin
            mode_d = pmt_pkg::MODE_DASH;
            held_d = byte_i;
            two_d  = 1'b0;
            pend_d = 1'b1;
          end else if (is_move_start(byte_i)) begin
            mode_d = pmt_pkg::MODE_TOKEN;
            held_d = byte_i;
            two_d  = 1'b0;
            pend_d = 1'b1;
          end else if (byte_i == ChBraceOpen) begin
            mode_d = pmt_pkg::MODE_BRACE;
          end else if (byte_i == ChSemi) begin
            mode_d = pmt_pkg::MODE_LINE;
          end else if (byte_i == ChParOpen) begin
            mode_d  = pmt_pkg::MODE_VAR;
            depth_d = DepthW'(1);
          end else begin
            stray = 1'b1;
          end
        end
        pmt_pkg::MODE_DASH: begin
          if (byte_i == ChDash) begin
            st.count = 2'd1;
            st.res0  = mk_char(held_q, 1'b1, 1'b0);
            held_d   = byte_i;
            two_d    = 1'b1;
            pend_d   = 1'b0;
            mode_d   = pmt_pkg::MODE_TOKEN;
          end else begin
            stray = 1'b1;
          end
        end
        pmt_pkg::MODE_TOKEN: begin
          st.count = 2'd1;
          if (two_q && is_token_end(byte_i)) begin
            st.res0 = mk_char(held_q, pend_q, 1'b1);
            mode_d  = pmt_pkg::MODE_SEEK;
            held_d  = '0;
            two_d   = 1'b0;
            pend_d  = 1'b0;
          end else begin
            st.res0 = mk_char(held_q, pend_q, 1'b0);
            held_d  = byte_i;
            two_d   = 1'b1;
            pend_d  = 1'b0;
          end
        end
        pmt_pkg::MODE_BRACE: begin
          if (byte_i == ChBraceClose) mode_d = pmt_pkg::MODE_SEEK;
        end
        pmt_pkg::MODE_LINE: begin
          if (byte_i == ChNewline) mode_d = pmt_pkg::MODE_SEEK;
        end
        pmt_pkg::MODE_VAR: begin
          if (byte_i == ChParOpen) begin
            if (depth_q < MaxNestD) depth_d = depth_q + 1'b1;
          end else if (byte_i == ChParClose) begin
            depth_d = depth_dec;
            if (depth_dec == '0) mode_d = pmt_pkg::MODE_SEEK;
          end else if (byte_i == ChBraceOpen) begin
            mode_d = pmt_pkg::MODE_VAR_BRACE;
          end else if (byte_i == ChSemi) begin
            mode_d = pmt_pkg::MODE_VAR_LINE;
          end
        end
        pmt_pkg::MODE_VAR_BRACE: begin
          if (byte_i == ChBraceClose) mode_d = pmt_pkg::MODE_VAR;
        end
        pmt_pkg::MODE_VAR_LINE: begin
          if (byte_i == ChNewline) mode_d = pmt_pkg::MODE_VAR;
        end
        default: begin
          mode_d = pmt_pkg::MODE_SEEK;
        end
      endcase

      if (stray) begin
        // stop early: later bytes are dropped until the end of the section
        st.count  = 2'd1;
        st.res0   = mk_done(pmt_pkg::CAUSE_STRAY);
        stopped_d = !last_i;
        start_d   = last_i;
      end else if (last_i) begin
        case (mode_d)
          pmt_pkg::MODE_TOKEN: begin
            if (two_d) begin
              fin              = mk_char(held_d, pend_d, 1'b1);
              fin.section_done = 1'b1;
              fin.stop_cause   = pmt_pkg::CAUSE_TEXT_END;
            end else begin
              fin = mk_done(pmt_pkg::CAUSE_TEXT_END);
            end
          end
          pmt_pkg::MODE_DASH: fin = mk_done(pmt_pkg::CAUSE_STRAY);
          pmt_pkg::MODE_SEEK: fin = mk_done(pmt_pkg::CAUSE_TEXT_END);
          default:            fin = mk_done(pmt_pkg::CAUSE_UNCLOSED);
        endcase
        if (st.count == 2'd0) begin
          st.res0  = fin;
          st.count = 2'd1;
        end else begin
          st.res1  = fin;
          st.count = 2'd2;
        end
        start_d = 1'b1;
      end
    end

    // re-arm for the next section, also after an early stop
    if (last_i) begin
      mode_d  = pmt_pkg::MODE_SEEK;
      depth_d = '0;
      held_d  = '0;
      two_d   = 1'b0;
      pend_d  = 1'b0;
    end
  end

  assign step_o = st;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= pmt_pkg::MODE_SEEK;
      depth_q   <= '0;
      held_q    <= '0;
      two_q     <= 1'b0;
      start_q   <= 1'b1;
      stopped_q <= 1'b0;
      pend_q    <= 1'b0;
    end else if (step_i) begin
      mode_q    <= mode_d;
      depth_q   <= depth_d;
      held_q    <= held_d;
      two_q     <= two_d;
      start_q   <= start_d;
      stopped_q <= stopped_d;
      pend_q    <= pend_d;
    end
  end

  a_stopped_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped_q |-> st.count == 2'd0)
    else $error("stopped section produced a result");

  a_second_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st.count == 2'd2 |-> st.res1.section_done && !st.res0.section_done)
    else $error("second result of a byte is not the section end");

  a_depth_in_var: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == pmt_pkg::MODE_VAR) |-> depth_q != '0)
    else $error("variation open with zero depth");

endmodule

FILE: src/pmt_result_fifo.sv
// small result queue: up to two writes and one read per cycle
module pmt_result_fifo (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [1:0]                      wr_n_i,
  input  pmt_pkg::pmt_result_t            wr0_i,
  input  pmt_pkg::pmt_result_t            wr1_i,
  input  logic                            pop_i,
  output pmt_pkg::pmt_result_t            head_o,
  output logic [pmt_pkg::ResCntW-1:0]     count_o
);

  pmt_pkg::pmt_result_t              mem_q [pmt_pkg::ResDepth];
  logic [pmt_pkg::ResPtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [pmt_pkg::ResPtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [pmt_pkg::ResCntW-1:0]       count_q, count_d;
  logic [pmt_pkg::ResPtrW-1:0]       wr_ptr_nx;

  assign wr_ptr_nx = wr_ptr_q + 1'b1;

  always_comb begin
    wr_ptr_d = wr_ptr_q + wr_n_i;
    rd_ptr_d = rd_ptr_q + pmt_pkg::ResPtrW'(pop_i);
    count_d  = count_q + pmt_pkg::ResCntW'(wr_n_i) - pmt_pkg::ResCntW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (wr_n_i != 2'd0) mem_q[wr_ptr_q]  <= wr0_i;
    if (wr_n_i == 2'd2) mem_q[wr_ptr_nx] <= wr1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assign head_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q + pmt_pkg::ResCntW'(wr_n_i)) <= pmt_pkg::ResCntW'(pmt_pkg::ResDepth)
      + pmt_pkg::ResCntW'(pop_i))
    else $error("result queue overflow");

endmodule

FILE: src/pgn_movetext_tokenizer_core.sv
// pgn movetext tokenizer: top level with input stage and result queue
//
// Slave stream s_axis carries one movetext byte per request, tlast on the
// final byte of a game's section. Master stream m_axis carries one result
// per request: a token character with first/final marks in tuser, and
// tlast (section_done) with the stop cause on the result that ends a section.
// A byte is registered in the input stage, decoded against the scan state once
// the queue has room and its results written to a four-entry queue, so the
// first result is offered on m_axis from the queue, after the input stage.
// Throughput is one byte per cycle; the stage moves on when the queue has
// room for two results, which is what the final byte of a section may give.
// Bytes that give no result (blanks, comments, variations) still take a scan step.
// Reset clears the queue and arms the scan for the start of a new section.
// When the receiver stalls the queue fills and tready drops; nothing is lost.
module pgn_movetext_tokenizer_core #(
  parameter int unsigned MAX_NEST = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic        s_axis_tlast,   // section_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] move_char, [9:8] stop_cause, rest zero
  output logic [2:0]  m_axis_tuser,   // [0] char_valid, [1] token_first, [2] token_final
  output logic        m_axis_tlast    // section_done
);

  logic                             stg_valid_q;
  logic [7:0]                       stg_byte_q;
  logic                             stg_last_q;
  logic                             advance;
  logic                             s_take;
  logic                             pop;
  logic [pmt_pkg::ResCntW-1:0]      q_count;
  logic [1:0]                       wr_n;
  pmt_pkg::pmt_step_t               step;
  pmt_pkg::pmt_result_t             head;

  assign advance       = stg_valid_q &&
                         (q_count <= pmt_pkg::ResCntW'(pmt_pkg::ResDepth - 2));
  assign s_axis_tready = !stg_valid_q || advance;
  assign s_take        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      stg_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_take) begin
      stg_byte_q <= s_axis_tdata;
      stg_last_q <= s_axis_tlast;
    end
  end

  pmt_lexer #(
    .MAX_NEST (MAX_NEST)
  ) u_lexer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (stg_byte_q),
    .last_i (stg_last_q),
    .step_o (step)
  );

  assign wr_n = advance ? step.count : 2'd0;

  pmt_result_fifo u_result_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_n_i  (wr_n),
    .wr0_i   (step.res0),
    .wr1_i   (step.res1),
    .pop_i   (pop),
    .head_o  (head),
    .count_o (q_count)
  );

  assign m_axis_tvalid = q_count != '0;
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata  = {6'd0, head.stop_cause, head.move_char};
  assign m_axis_tuser  = {head.token_final, head.token_first, head.char_valid};
  assign m_axis_tlast  = head.section_done;

endmodule
